// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset masking.
`define CLWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, for a property that only holds while the output word is valid.
`define CLWS_ASSERT_VLD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (prop)) \
    else $error(msg);

`endif

// File: src/clws_pkg.sv
// Types and constants for the character LCD write sequencer.
`default_nettype none

package clws_pkg;

  localparam logic [2:0] MODE_DATA   = 3'd0;
  localparam logic [2:0] MODE_INSTR  = 3'd1;
  localparam logic [2:0] MODE_INIT   = 3'd2;
  localparam logic [2:0] MODE_CURSOR = 3'd3;
  localparam logic [2:0] MODE_NUMBER = 3'd4;

  localparam logic [1:0] CFG_BUS_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ENABLE_HOLD = 2'd1;
  localparam logic [1:0] CFG_POWER_WAIT = 2'd2;

  localparam logic [7:0] POWER_WAIT_RST = 8'd30;

  localparam logic [7:0] INIT_FUNC_8B   = 8'b0011_1000;
  localparam logic [7:0] INIT_DISP_ON   = 8'b0000_1111;
  localparam logic [7:0] INIT_CLEAR     = 8'b0000_0001;
  localparam logic [7:0] INIT_NIB_FUNC  = 8'b0000_0010;
  localparam logic [7:0] INIT_NIB_LINES = 8'b0000_1000;
  localparam logic [7:0] LINE_OFFSET    = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // x / 10 == (x * 0xCCCD) >> 19 for any 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;
  localparam int          NUM_DIGITS  = 5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] value;
    logic [5:0]  column;
    logic        row;
  } in_word_t;

  typedef struct packed {
    logic [7:0] bus_value;
    logic       register_select;
    logic [7:0] wait_before_ms;
    logic       last_strobe;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic conv_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_ok;
    logic mode_num;
    logic conv_done;
    logic is_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: src/clws_dp.sv
// Datapath: config registers, request capture, digit conversion, strobe word.
`default_nettype none

module clws_dp
  import clws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_word_t   in_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire dp_cmd_t    cmd,
  output dp_sts_t         sts,
  output out_word_t       out_data
);

  logic        bus_four_r;
  logic [7:0]  power_wait_r;

  logic [2:0]  mode_r;
  logic [7:0]  byte_r;
  logic [15:0] num_r;
  logic [3:0]  dig_r [NUM_DIGITS];
  logic [2:0]  cnt_r;
  logic [2:0]  idx_r;
  logic        half_r;
  out_word_t   out_r;

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] quot_x10;
  logic [3:0]  rem;
  logic [7:0]  cursor_byte;
  logic [7:0]  ent_byte;
  logic        ent_single;
  logic [2:0]  nent;
  logic [3:0]  dig_sel;
  logic        ent_last;
  logic        strobe_last;
  out_word_t   strobe;

  // enable hold time is applied downstream; the write is accepted and dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_four_r   <= 1'b1;
      power_wait_r <= POWER_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUS_WIDTH:   bus_four_r   <= cfg_data[0];
        CFG_POWER_WAIT:  power_wait_r <= cfg_data;
        CFG_ENABLE_HOLD: ;
        default: ;
      endcase
    end
  end

  assign prod     = 32'(num_r) * 32'(DIV10_MUL);
  assign quot     = 16'(prod >> DIV10_SHIFT);
  assign quot_x10 = 16'({quot, 3'b000} + {2'b00, quot, 1'b0});
  assign rem      = 4'(num_r - quot_x10);

  assign cursor_byte = CMD_SET_DDRAM
                     | 8'({2'b00, in_data.column} + (in_data.row ? LINE_OFFSET : 8'h00));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_data.mode;
      num_r  <= in_data.value;
      byte_r <= (in_data.mode == MODE_CURSOR) ? cursor_byte : in_data.value[7:0];
      cnt_r  <= '0;
      idx_r  <= '0;
      half_r <= 1'b0;
    end else begin
      if (cmd.conv_step) begin
        num_r    <= quot;
        cnt_r    <= cnt_r + 3'd1;
        dig_r[0] <= rem;
        for (int k = 1; k < NUM_DIGITS; k++) begin
          dig_r[k] <= dig_r[k-1];
        end
      end
      if (cmd.load_out) begin
        if (bus_four_r && !ent_single && !half_r) begin
          half_r <= 1'b1;
        end else begin
          half_r <= 1'b0;
          idx_r  <= idx_r + 3'd1;
        end
      end
    end
  end

  always_comb begin
    unique case (idx_r)
      3'd0:    dig_sel = dig_r[0];
      3'd1:    dig_sel = dig_r[1];
      3'd2:    dig_sel = dig_r[2];
      3'd3:    dig_sel = dig_r[3];
      3'd4:    dig_sel = dig_r[4];
      default: dig_sel = '0;
    endcase
  end

  always_comb begin
    ent_byte   = byte_r;
    ent_single = 1'b0;
    nent       = 3'd1;
    unique case (mode_r)
      MODE_INIT: begin
        if (bus_four_r) begin
          nent = 3'd5;
          unique case (idx_r)
            3'd0, 3'd1: begin
              ent_byte   = INIT_NIB_FUNC;
              ent_single = 1'b1;
            end
            3'd2: begin
              ent_byte   = INIT_NIB_LINES;
              ent_single = 1'b1;
            end
            3'd3:    ent_byte = INIT_DISP_ON;
            default: ent_byte = INIT_CLEAR;
          endcase
        end else begin
          nent = 3'd3;
          unique case (idx_r)
            3'd0:    ent_byte = INIT_FUNC_8B;
            3'd1:    ent_byte = INIT_DISP_ON;
            default: ent_byte = INIT_CLEAR;
          endcase
        end
      end
      MODE_NUMBER: begin
        nent     = cnt_r;
        ent_byte = {ASCII_DIGIT_HI, dig_sel};
      end
      default: ;
    endcase
  end

  assign ent_last    = (idx_r == nent - 3'd1);
  assign strobe_last = ent_last && (!bus_four_r || ent_single || half_r);

  always_comb begin
    strobe.register_select = (mode_r == MODE_DATA) || (mode_r == MODE_NUMBER);
    strobe.wait_before_ms  = (mode_r == MODE_INIT && idx_r == 3'd0 && !half_r)
                           ? power_wait_r : 8'd0;
    strobe.last_strobe     = strobe_last;
    if (!bus_four_r) begin
      strobe.bus_value = ent_byte;
    end else if (ent_single || half_r) begin
      strobe.bus_value = {4'h0, ent_byte[3:0]};
    end else begin
      strobe.bus_value = {4'h0, ent_byte[7:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= strobe;
    end
  end

  assign out_data = out_r;

  assign sts.mode_ok   = (mode_r <= MODE_NUMBER);
  assign sts.mode_num  = (mode_r == MODE_NUMBER);
  assign sts.conv_done = (quot == 16'd0);
  assign sts.is_last   = strobe_last;

endmodule

`default_nettype wire

// File: src/clws_ctrl.sv
// Controller: request sequencing and output valid handling.
`default_nettype none

module clws_ctrl
  import clws_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_START;
        end
      end
      ST_START: begin
        if (!sts.mode_ok) begin
          state_nxt = ST_IDLE;
        end else if (sts.mode_num) begin
          state_nxt = ST_CONV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: src/char_lcd_write_sequencer_core.sv
// Top level of the character LCD write sequencer.
// Each request word becomes a run of enable-strobe words: bus value, register select, wait
// before the strobe and a last-strobe mark; the display side applies the millisecond timing.
// One request is handled at a time: the request is captured, a decimal number is then
// converted digit by digit in the divide-by-ten unit (up to 5 digits), and each strobe leaves
// through the output register, one per cycle when the result side does not stall. The next
// request is taken once the final strobe is loaded, even while it still waits in the output
// register. Unused modes give no strobes.
// Config writes are always ready and take effect immediately; write them only when idle.
`default_nettype none

module char_lcd_write_sequencer_core
  import clws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  clws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  clws_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: src/clws_checker.sv
// Port-level checker for the sequencer and its bind.
`default_nettype none
`include "assert_macros.svh"

module clws_checker
  import clws_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  `CLWS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output word changed")
  `CLWS_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "word accepted while busy")
  `CLWS_ASSERT_VLD(a_busy_mid_request, out_data.last_strobe || in_stall, "new word taken before last strobe")
  `CLWS_ASSERT_VLD(a_wait_is_instr, out_data.wait_before_ms == 8'd0 || !out_data.register_select, "power-up wait on data strobe")

endmodule

bind char_lcd_write_sequencer_core clws_checker u_clws_checker (.*);

`default_nettype wire
